/* hdl/crp_pkg.sv */
// Shared types and codes for the rotor permutation block.
// Holds the item payload structs, opcodes, error codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package crp_pkg;

  localparam int SymW  = 5;
  localparam int OpW   = 3;
  localparam int ErrW  = 2;

  localparam logic [OpW-1:0] OP_LOAD     = 3'd0;
  localparam logic [OpW-1:0] OP_VALIDATE = 3'd1;
  localparam logic [OpW-1:0] OP_SET      = 3'd2;
  localparam logic [OpW-1:0] OP_ROTATE   = 3'd3;
  localparam logic [OpW-1:0] OP_FWD      = 3'd4;
  localparam logic [OpW-1:0] OP_REV      = 3'd5;

  localparam logic [ErrW-1:0] ERR_NONE    = 2'd0;
  localparam logic [ErrW-1:0] ERR_RANGE   = 2'd1;
  localparam logic [ErrW-1:0] ERR_DUP     = 2'd2;
  localparam logic [ErrW-1:0] ERR_NOT_BIJ = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [SymW-1:0] entry_index;
    logic [SymW-1:0] symbol;
  } crp_in_t;

  typedef struct packed {
    logic [SymW-1:0] mapped_letter;
    logic            carry;
    logic [ErrW-1:0] error_code;
  } crp_out_t;

  typedef struct packed {
    logic            latch;
    logic            fwd_wr;
    logic            pos_set;
    logic            pos_step;
    logic            map_rd;
    logic            cnt_clr;
    logic            cnt_inc;
    logic            fwd_rd_cnt;
    logic            seen_clr;
    logic            seen_rd;
    logic            seen_set;
    logic            inv_wr;
    logic            res_ld;
    logic            res_map;
    logic            res_carry;
    logic [ErrW-1:0] res_err;
  } crp_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           idx_ok;
    logic           sym_ok;
    logic           fwd_val_ok;
    logic           seen_hit;
    logic           cnt_last;
  } crp_status_t;

endpackage

`default_nettype wire

/* hdl/cipher_rotor_permutation.sv */
// Top level of one cipher rotor: wiring load and check, position control,
// forward and reverse letter mapping.
// Depends on crp_pkg, crp_ctrl and crp_dpath.
//
//   Channel  Handshake               Payload
//   in       in_valid_i/in_ready_o   in_data_i  (crp_in_t)
//   out      out_valid_o/out_ready_i out_data_o (crp_out_t)
//   config   cfg_we_i                cfg_data_i (notch position)
//
// Load, set, rotate, forward and reverse items each go through an accept,
// an execute (one memory access or register update) and a result step.
// A validate item runs the seen-mark clear sweep, then the check walk over
// each entry and, if the walk is clean, the inverse build.
// Reset clears position, notch and control; the tables need no clearing.
// A new item is accepted while a result waits in the output register; the
// next result then holds until that register is taken.
`default_nettype none

module cipher_rotor_permutation #(
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire crp_pkg::crp_in_t         in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output crp_pkg::crp_out_t             out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [crp_pkg::SymW-1:0] cfg_data_i
);

  crp_pkg::crp_cmd_t    cmd;
  crp_pkg::crp_status_t status;

  crp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  crp_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* hdl/crp_dpath.sv */
// Datapath of the rotor permutation block: item register, position and
// notch registers, wiring, inverse and seen-mark memories, result register.
// Depends on crp_pkg; driven by crp_ctrl through crp_cmd_t.
`default_nettype none

module crp_dpath #(
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire crp_pkg::crp_in_t      in_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [crp_pkg::SymW-1:0] cfg_data_i,
  input  wire crp_pkg::crp_cmd_t     cmd_i,
  output crp_pkg::crp_status_t       status_o,
  output crp_pkg::crp_out_t          out_data_o
);

  localparam int PW   = $clog2(ALPHABET_SIZE);
  localparam int CW   = ((PW > crp_pkg::SymW) ? PW : crp_pkg::SymW) + 1;
  localparam int LutN = 2 ** crp_pkg::SymW;
  localparam logic [CW-1:0] NCw  = CW'(ALPHABET_SIZE);
  localparam logic [PW:0]   NPw1 = (PW+1)'(ALPHABET_SIZE);
  localparam logic [PW-1:0] Last = PW'(ALPHABET_SIZE - 1);

  logic [crp_pkg::OpW-1:0]  op_q;
  logic [crp_pkg::SymW-1:0] idx_q;
  logic [crp_pkg::SymW-1:0] sym_q;
  logic [PW-1:0]            pos_q, pos_d;
  logic [crp_pkg::SymW-1:0] notch_q;
  logic [PW-1:0]            cnt_q, cnt_d;

  logic [crp_pkg::SymW-1:0] fwd_mem [ALPHABET_SIZE];
  logic [PW-1:0]            inv_mem [ALPHABET_SIZE];
  logic                     seen_mem [ALPHABET_SIZE];
  logic [crp_pkg::SymW-1:0] fwd_rdata_q;
  logic [PW-1:0]            inv_rdata_q;
  logic                     seen_rdata_q;

  crp_pkg::crp_out_t        out_q, out_d;

  // Residue of every 5-bit wiring value; covers unvalidated stored values.
  logic [PW-1:0] mod_lut [LutN];
  for (genvar g = 0; g < LutN; g++) begin : g_mod_lut
    assign mod_lut[g] = PW'(g % ALPHABET_SIZE);
  end

  logic [CW-1:0] idx_ext, sym_ext, fv_ext, notch_ext, pos_ext, letter_ext;
  logic [PW-1:0] idx_addr, sym_p, fv_addr, map_addr, fwd_raddr, v_red, letter;
  logic [PW:0]   map_sum, letter_sum;
  logic          fwd_rd_en, inv_rd_en, carry_now;

  assign idx_ext   = CW'(idx_q);
  assign sym_ext   = CW'(sym_q);
  assign fv_ext    = CW'(fwd_rdata_q);
  assign notch_ext = CW'(notch_q);
  assign pos_ext   = CW'(pos_q);
  assign idx_addr  = idx_ext[PW-1:0];
  assign sym_p     = sym_ext[PW-1:0];
  assign fv_addr   = fv_ext[PW-1:0];

  // Letter plus position, reduced by one conditional subtract.
  always_comb begin
    map_sum = {1'b0, sym_p} + {1'b0, pos_q};
    if (map_sum >= NPw1) begin
      map_sum = map_sum - NPw1;
    end
    map_addr = map_sum[PW-1:0];
  end

  assign fwd_raddr = cmd_i.map_rd ? map_addr : cnt_q;
  assign fwd_rd_en = (cmd_i.map_rd && (op_q == crp_pkg::OP_FWD)) || cmd_i.fwd_rd_cnt;
  assign inv_rd_en = cmd_i.map_rd && (op_q == crp_pkg::OP_REV);

  // Table value minus position, wrapped into the alphabet.
  always_comb begin
    v_red = (op_q == crp_pkg::OP_REV) ? inv_rdata_q : mod_lut[fwd_rdata_q];
    if (v_red >= pos_q) begin
      letter_sum = {1'b0, v_red} - {1'b0, pos_q};
    end else begin
      letter_sum = {1'b0, v_red} + NPw1 - {1'b0, pos_q};
    end
    letter     = letter_sum[PW-1:0];
    letter_ext = CW'(letter);
  end

  assign carry_now = (pos_ext == notch_ext);

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_set) begin
      pos_d = sym_p;
    end else if (cmd_i.pos_step) begin
      pos_d = (pos_q == Last) ? '0 : pos_q + PW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + PW'(1);
    end
  end

  always_comb begin
    out_d.mapped_letter = cmd_i.res_map ? letter_ext[crp_pkg::SymW-1:0] : '0;
    out_d.carry         = cmd_i.res_carry ? carry_now : 1'b0;
    out_d.error_code    = cmd_i.res_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      notch_q <= '0;
      cnt_q   <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        notch_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= in_data_i.opcode;
      idx_q <= in_data_i.entry_index;
      sym_q <= in_data_i.symbol;
    end
    if (cmd_i.res_ld) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fwd_wr) begin
      fwd_mem[idx_addr] <= sym_q;
    end
    if (fwd_rd_en) begin
      fwd_rdata_q <= fwd_mem[fwd_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.inv_wr) begin
      inv_mem[fv_addr] <= cnt_q;
    end
    if (inv_rd_en) begin
      inv_rdata_q <= inv_mem[map_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seen_clr) begin
      seen_mem[cnt_q] <= 1'b0;
    end else if (cmd_i.seen_set) begin
      seen_mem[fv_addr] <= 1'b1;
    end
    if (cmd_i.seen_rd) begin
      seen_rdata_q <= seen_mem[fv_addr];
    end
  end

  assign status_o.op         = op_q;
  assign status_o.idx_ok     = (idx_ext < NCw);
  assign status_o.sym_ok     = (sym_ext < NCw);
  assign status_o.fwd_val_ok = (fv_ext < NCw);
  assign status_o.seen_hit   = seen_rdata_q;
  assign status_o.cnt_last   = (cnt_q == Last);
  assign out_data_o          = out_q;

endmodule

`default_nettype wire

/* hdl/crp_ctrl.sv */
// Controller of the rotor permutation block: item sequencing, the wiring
// check walk, the inverse build and the result register handshake.
// Depends on crp_pkg; drives crp_dpath through crp_cmd_t.
`default_nettype none

module crp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire crp_pkg::crp_status_t status_i,
  output crp_pkg::crp_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_VRD   = 4'd3;
  localparam logic [3:0] S_VCHK1 = 4'd4;
  localparam logic [3:0] S_VCHK2 = 4'd5;
  localparam logic [3:0] S_BRD   = 4'd6;
  localparam logic [3:0] S_BWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                state_q, state_d;
  logic [crp_pkg::ErrW-1:0]  err_q, err_d;
  logic                      map_q, map_d;
  logic                      carry_q, carry_d;
  logic                      out_valid_q, out_valid_d;
  logic                      slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    map_d       = map_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.res_err   = err_q;
    cmd_o.res_map   = map_q;
    cmd_o.res_carry = carry_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          err_d       = crp_pkg::ERR_NONE;
          map_d       = 1'b0;
          carry_d     = 1'b0;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (status_i.op)
          crp_pkg::OP_LOAD: begin
            cmd_o.fwd_wr = status_i.idx_ok;
            err_d = status_i.idx_ok ? crp_pkg::ERR_NONE : crp_pkg::ERR_RANGE;
          end
          crp_pkg::OP_VALIDATE: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_CLR;
          end
          crp_pkg::OP_SET: begin
            cmd_o.pos_set = status_i.sym_ok;
            err_d = status_i.sym_ok ? crp_pkg::ERR_NONE : crp_pkg::ERR_RANGE;
          end
          crp_pkg::OP_ROTATE: begin
            cmd_o.pos_step = 1'b1;
            carry_d        = 1'b1;
          end
          crp_pkg::OP_FWD, crp_pkg::OP_REV: begin
            cmd_o.map_rd = status_i.sym_ok;
            map_d        = status_i.sym_ok;
            err_d = status_i.sym_ok ? crp_pkg::ERR_NONE : crp_pkg::ERR_RANGE;
          end
          default: begin
          end
        endcase
      end
      S_CLR: begin
        cmd_o.seen_clr = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_VRD;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_VRD: begin
        cmd_o.fwd_rd_cnt = 1'b1;
        state_d          = S_VCHK1;
      end
      S_VCHK1: begin
        if (!status_i.fwd_val_ok) begin
          err_d   = crp_pkg::ERR_RANGE;
          state_d = S_DONE;
        end else begin
          cmd_o.seen_rd = 1'b1;
          state_d       = S_VCHK2;
        end
      end
      S_VCHK2: begin
        if (status_i.seen_hit) begin
          err_d   = crp_pkg::ERR_DUP;
          state_d = S_DONE;
        end else begin
          cmd_o.seen_set = 1'b1;
          // N distinct in-range values cover the alphabet, so a clean walk
          // means a permutation and the inverse can be built.
          if (status_i.cnt_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_BRD;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = S_VRD;
          end
        end
      end
      S_BRD: begin
        cmd_o.fwd_rd_cnt = 1'b1;
        state_d          = S_BWR;
      end
      S_BWR: begin
        cmd_o.inv_wr = 1'b1;
        if (status_i.cnt_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_BRD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.res_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= crp_pkg::ERR_NONE;
      map_q       <= 1'b0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      map_q       <= map_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
